FILE: hdl/rpes_pkg.sv
// shared types and constants of the refuge population step unit
`default_nettype none
package rpes_pkg;

	localparam int DEF_STATE_WIDTH    = 32;
	localparam int DEF_COEF_FRAC_BITS = 24;

	localparam int FIELD_W   = 32;
	localparam int COEF_W    = 31;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_W     = 64;
	localparam int HALF_W    = MUL_W / 2;
	localparam int PHASE_W   = 3;

	// multiply sequence: partial products on phases 0..3, accumulate 1..4, write 5
	localparam logic [PHASE_W-1:0] PHASE_PP_LAST  = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_ACC_LAST = 3'd4;
	localparam logic [PHASE_W-1:0] PHASE_WR       = 3'd5;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GROWTH_RATE         = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CAPACITY        = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_REFUGE_CAPACITY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAR_GROWTH          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WAR_DECLINE         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FLEE_RATE           = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RETURN_RATE         = 3'd6;

	localparam logic [COEF_W-1:0] RST_GROWTH_RATE         = 31'd167772;
	localparam logic [COEF_W-1:0] RST_INV_CAPACITY        = 31'd16777;
	localparam logic [COEF_W-1:0] RST_INV_REFUGE_CAPACITY = 31'd167772;
	localparam logic [COEF_W-1:0] RST_WAR_GROWTH          = 31'd1677722;
	localparam logic [COEF_W-1:0] RST_WAR_DECLINE         = 31'd167772;
	localparam logic [COEF_W-1:0] RST_FLEE_RATE           = 31'd167772;
	localparam logic [COEF_W-1:0] RST_RETURN_RATE         = 31'd167772;

	typedef struct packed {
		logic               opcode;
		logic [FIELD_W-1:0] init_warfare;
		logic [FIELD_W-1:0] init_population;
		logic [FIELD_W-1:0] init_refuge;
	} in_item_t;

	typedef struct packed {
		logic [FIELD_W-1:0] warfare_out;
		logic [FIELD_W-1:0] population_out;
		logic [FIELD_W-1:0] refuge_out;
		logic               saturated;
	} out_item_t;

	typedef struct packed {
		logic [COEF_W-1:0] growth_rate;
		logic [COEF_W-1:0] inv_capacity;
		logic [COEF_W-1:0] inv_refuge_capacity;
		logic [COEF_W-1:0] war_growth;
		logic [COEF_W-1:0] war_decline;
		logic [COEF_W-1:0] flee_rate;
		logic [COEF_W-1:0] return_rate;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_ADV,
		ST_FINISH
	} ctrl_state_t;

	// products of one step, in dependency order
	typedef enum logic [3:0] {
		MOP_AY,
		MOP_AYK,
		MOP_XPOS,
		MOP_XNEG,
		MOP_RY,
		MOP_YK,
		MOP_RY2,
		MOP_CX,
		MOP_CXY,
		MOP_DZZ,
		MOP_RZ,
		MOP_ZR,
		MOP_RZ2
	} mul_op_t;

	// which 32-bit halves form a partial product (a half, b half)
	typedef enum logic [1:0] {
		PP_LL,
		PP_LH,
		PP_HL,
		PP_HH
	} pp_sel_t;

	typedef enum logic [1:0] {
		ADV_X,
		ADV_Y,
		ADV_Z
	} adv_sel_t;

	typedef struct packed {
		logic     start;
		logic     load_state;
		mul_op_t  mul_op;
		logic     mul_pp_en;
		pp_sel_t  mul_pp;
		logic     mul_acc_en;
		logic     mul_wr;
		logic     sum_en;
		logic     adv_en;
		adv_sel_t adv_sel;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic    pp_en;
		pp_sel_t pp;
		logic    acc_en;
		logic    state_frac;
	} mul_cmd_t;

endpackage
`default_nettype wire

FILE: hdl/rpes_cfg_regs.sv
// coefficient register bank with plain write port
`default_nettype none
module rpes_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rpes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rpes_pkg::COEF_W-1:0]    cfg_data,
	output rpes_pkg::cfg_t                      cfg
);
	import rpes_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.growth_rate         <= RST_GROWTH_RATE;
			cfg_q.inv_capacity        <= RST_INV_CAPACITY;
			cfg_q.inv_refuge_capacity <= RST_INV_REFUGE_CAPACITY;
			cfg_q.war_growth          <= RST_WAR_GROWTH;
			cfg_q.war_decline         <= RST_WAR_DECLINE;
			cfg_q.flee_rate           <= RST_FLEE_RATE;
			cfg_q.return_rate         <= RST_RETURN_RATE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GROWTH_RATE:         cfg_q.growth_rate         <= cfg_data;
				REG_INV_CAPACITY:        cfg_q.inv_capacity        <= cfg_data;
				REG_INV_REFUGE_CAPACITY: cfg_q.inv_refuge_capacity <= cfg_data;
				REG_WAR_GROWTH:          cfg_q.war_growth          <= cfg_data;
				REG_WAR_DECLINE:         cfg_q.war_decline         <= cfg_data;
				REG_FLEE_RATE:           cfg_q.flee_rate           <= cfg_data;
				REG_RETURN_RATE:         cfg_q.return_rate         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: hdl/rpes_mul.sv
// 64x64 fixed-point multiplier built from one 32x32 multiplier, one partial product at a time
`default_nettype none
module rpes_mul #(
	parameter int COEF_FRAC_BITS  = rpes_pkg::DEF_COEF_FRAC_BITS,
	parameter int STATE_FRAC_BITS = rpes_pkg::DEF_STATE_WIDTH / 2
) (
	input  wire logic                       clk,
	input  wire rpes_pkg::mul_cmd_t         cmd,
	input  wire logic [rpes_pkg::MUL_W-1:0] a,
	input  wire logic [rpes_pkg::MUL_W-1:0] b,
	output logic      [rpes_pkg::MUL_W-1:0] result
);
	import rpes_pkg::*;

	logic [HALF_W-1:0]  a_half, b_half;
	logic [MUL_W-1:0]   pp_c;
	logic [MUL_W-1:0]   pp_s1;
	pp_sel_t            sel_s1;
	logic [2*MUL_W-1:0] pp_ext, pp_shifted;
	logic [2*MUL_W-1:0] acc_q;
	logic [2*MUL_W-1:0] prod_c, prod_s, prod_sel;

	assign a_half = (cmd.pp == PP_HL || cmd.pp == PP_HH) ? a[MUL_W-1:HALF_W] : a[HALF_W-1:0];
	assign b_half = (cmd.pp == PP_LH || cmd.pp == PP_HH) ? b[MUL_W-1:HALF_W] : b[HALF_W-1:0];
	assign pp_c   = a_half * b_half;

	assign pp_ext = {{MUL_W{1'b0}}, pp_s1};

	always_comb begin
		case (sel_s1) inside
			PP_LL:        pp_shifted = pp_ext;
			PP_LH, PP_HL: pp_shifted = pp_ext << HALF_W;
			PP_HH:        pp_shifted = pp_ext << MUL_W;
			default:      pp_shifted = pp_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.pp_en) begin
			pp_s1  <= pp_c;
			sel_s1 <= cmd.pp;
		end
		// the low-low partial product always comes first and restarts the sum
		if (cmd.acc_en) begin
			acc_q <= ((sel_s1 == PP_LL) ? '0 : acc_q) + pp_shifted;
		end
	end

	assign prod_c   = acc_q >> COEF_FRAC_BITS;
	assign prod_s   = acc_q >> STATE_FRAC_BITS;
	assign prod_sel = cmd.state_frac ? prod_s : prod_c;
	assign result   = (|prod_sel[2*MUL_W-1:MUL_W]) ? '1 : prod_sel[MUL_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/rpes_datapath.sv
// state, product temporaries, difference sums, advance unit and output register
`default_nettype none
module rpes_datapath #(
	parameter int STATE_WIDTH    = rpes_pkg::DEF_STATE_WIDTH,
	parameter int COEF_FRAC_BITS = rpes_pkg::DEF_COEF_FRAC_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rpes_pkg::dp_cmd_t  cmd,
	input  wire rpes_pkg::cfg_t     cfg,
	input  wire rpes_pkg::in_item_t in_item,
	output rpes_pkg::out_item_t     out_item
);
	import rpes_pkg::*;

	localparam int STATE_FRAC = STATE_WIDTH / 2;
	localparam int ADV_W      = MUL_W + 2;
	localparam logic [ADV_W-1:0] ADV_ONE = ADV_W'(1);
	localparam logic [ADV_W-1:0] SMAX    = (ADV_ONE << STATE_WIDTH) - ADV_ONE;

	function automatic logic [MUL_W-1:0] sat_add(input logic [MUL_W-1:0] p,
			input logic [MUL_W-1:0] q);
		logic [MUL_W:0] s;
		s = {1'b0, p} + {1'b0, q};
		return s[MUL_W] ? '1 : s[MUL_W-1:0];
	endfunction

	logic [STATE_WIDTH-1:0] x_q, y_q, z_q;
	logic                   sat_q;

	logic [MUL_W-1:0] ay_q, ayk_q, xpos_q, xneg_q, ry_q, yk_q, ry2_q;
	logic [MUL_W-1:0] cx_q, cxy_q, dzz_q, rz_q, zr_q, rz2_q;
	logic [MUL_W-1:0] posy_q, negy_q, posz_q, negz_q;

	logic [MUL_W-1:0] x_w, y_w, z_w;
	logic [MUL_W-1:0] mul_a, mul_b, mul_res;
	mul_cmd_t         mul_cmd;
	logic             state_frac;

	logic [MUL_W-1:0]       adv_old, adv_pos, adv_neg;
	logic [ADV_W-1:0]       adv_tot, adv_diff;
	logic                   adv_under, adv_over;
	logic [STATE_WIDTH-1:0] adv_new;

	out_item_t out_q;

	assign x_w = MUL_W'(x_q);
	assign y_w = MUL_W'(y_q);
	assign z_w = MUL_W'(z_q);

	always_comb begin
		mul_a      = '0;
		mul_b      = '0;
		state_frac = 1'b0;
		case (cmd.mul_op)
			MOP_AY:   begin mul_a = MUL_W'(cfg.war_growth);  mul_b = y_w; end
			MOP_AYK:  begin mul_a = ay_q;  mul_b = MUL_W'(cfg.inv_capacity); end
			MOP_XPOS: begin mul_a = x_w;   mul_b = ayk_q; state_frac = 1'b1; end
			MOP_XNEG: begin mul_a = x_w;   mul_b = MUL_W'(cfg.war_decline); end
			MOP_RY:   begin mul_a = MUL_W'(cfg.growth_rate); mul_b = y_w; end
			MOP_YK:   begin mul_a = y_w;   mul_b = MUL_W'(cfg.inv_capacity); end
			MOP_RY2:  begin mul_a = ry_q;  mul_b = yk_q;  state_frac = 1'b1; end
			MOP_CX:   begin mul_a = MUL_W'(cfg.flee_rate);   mul_b = x_w; end
			MOP_CXY:  begin mul_a = cx_q;  mul_b = y_w;   state_frac = 1'b1; end
			MOP_DZZ:  begin mul_a = MUL_W'(cfg.return_rate); mul_b = z_w; end
			MOP_RZ:   begin mul_a = MUL_W'(cfg.growth_rate); mul_b = z_w; end
			MOP_ZR:   begin mul_a = z_w;   mul_b = MUL_W'(cfg.inv_refuge_capacity); end
			MOP_RZ2:  begin mul_a = rz_q;  mul_b = zr_q;  state_frac = 1'b1; end
			default: begin
			end
		endcase
	end

	assign mul_cmd.pp_en      = cmd.mul_pp_en;
	assign mul_cmd.pp         = cmd.mul_pp;
	assign mul_cmd.acc_en     = cmd.mul_acc_en;
	assign mul_cmd.state_frac = state_frac;

	rpes_mul #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS),
		.STATE_FRAC_BITS(STATE_FRAC)
	) u_mul (
		.clk   (clk),
		.cmd   (mul_cmd),
		.a     (mul_a),
		.b     (mul_b),
		.result(mul_res)
	);

	// shared advance unit: old + pos - neg, clamped to the state range
	always_comb begin
		case (cmd.adv_sel)
			ADV_X:   begin adv_old = x_w; adv_pos = xpos_q; adv_neg = xneg_q; end
			ADV_Y:   begin adv_old = y_w; adv_pos = posy_q; adv_neg = negy_q; end
			ADV_Z:   begin adv_old = z_w; adv_pos = posz_q; adv_neg = negz_q; end
			default: begin adv_old = x_w; adv_pos = xpos_q; adv_neg = xneg_q; end
		endcase
	end

	assign adv_tot   = ADV_W'(adv_old) + ADV_W'(adv_pos);
	assign adv_under = adv_tot < ADV_W'(adv_neg);
	assign adv_diff  = adv_tot - ADV_W'(adv_neg);
	assign adv_over  = !adv_under && (adv_diff > SMAX);
	assign adv_new   = adv_under ? '0 :
	                   adv_over  ? SMAX[STATE_WIDTH-1:0] : adv_diff[STATE_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			z_q   <= '0;
			sat_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				sat_q <= 1'b0;
			end
			if (cmd.load_state) begin
				x_q <= STATE_WIDTH'(in_item.init_warfare);
				y_q <= STATE_WIDTH'(in_item.init_population);
				z_q <= STATE_WIDTH'(in_item.init_refuge);
			end
			if (cmd.adv_en) begin
				if (adv_over) begin
					sat_q <= 1'b1;
				end
				case (cmd.adv_sel)
					ADV_X:   x_q <= adv_new;
					ADV_Y:   y_q <= adv_new;
					ADV_Z:   z_q <= adv_new;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_wr) begin
			case (cmd.mul_op)
				MOP_AY:   ay_q   <= mul_res;
				MOP_AYK:  ayk_q  <= mul_res;
				MOP_XPOS: xpos_q <= mul_res;
				MOP_XNEG: xneg_q <= mul_res;
				MOP_RY:   ry_q   <= mul_res;
				MOP_YK:   yk_q   <= mul_res;
				MOP_RY2:  ry2_q  <= mul_res;
				MOP_CX:   cx_q   <= mul_res;
				MOP_CXY:  cxy_q  <= mul_res;
				MOP_DZZ:  dzz_q  <= mul_res;
				MOP_RZ:   rz_q   <= mul_res;
				MOP_ZR:   zr_q   <= mul_res;
				MOP_RZ2:  rz2_q  <= mul_res;
				default: begin
				end
			endcase
		end
		if (cmd.sum_en) begin
			posy_q <= sat_add(ry_q, dzz_q);
			negy_q <= sat_add(ry2_q, cxy_q);
			posz_q <= sat_add(rz_q, cxy_q);
			negz_q <= sat_add(rz2_q, dzz_q);
		end
		if (cmd.out_load) begin
			out_q.warfare_out    <= FIELD_W'(x_q);
			out_q.population_out <= FIELD_W'(y_q);
			out_q.refuge_out     <= FIELD_W'(z_q);
			out_q.saturated      <= sat_q;
		end
	end

	assign out_item = out_q;

endmodule
`default_nettype wire

FILE: hdl/rpes_ctrl.sv
// sequencer for load and step items, with the output valid flag
`default_nettype none
module rpes_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic         opcode,
	output logic              in_stall,
	output logic              out_valid,
	input  wire logic         out_stall,
	output rpes_pkg::dp_cmd_t cmd
);
	import rpes_pkg::*;

	ctrl_state_t          state_q, state_d;
	mul_op_t              op_q, op_d;
	logic [PHASE_W-1:0]   phase_q, phase_d;
	adv_sel_t             adv_q, adv_d;
	logic                 out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= MOP_AY;
			phase_q     <= '0;
			adv_q       <= ADV_X;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			op_q        <= op_d;
			phase_q     <= phase_d;
			adv_q       <= adv_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		op_d        = op_q;
		phase_d     = phase_q;
		adv_d       = adv_q;
		out_valid_d = out_valid_q && out_stall;
		in_stall    = 1'b1;
		cmd         = '0;
		cmd.mul_op  = op_q;
		cmd.mul_pp  = pp_sel_t'(phase_q[1:0]);
		cmd.adv_sel = adv_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start      = 1'b1;
					cmd.load_state = (opcode == OP_LOAD);
					if (opcode == OP_STEP) begin
						state_d = ST_MUL;
						op_d    = MOP_AY;
						phase_d = '0;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_pp_en  = (phase_q <= PHASE_PP_LAST);
				cmd.mul_acc_en = (phase_q != '0) && (phase_q <= PHASE_ACC_LAST);
				cmd.mul_wr     = (phase_q == PHASE_WR);
				if (phase_q == PHASE_WR) begin
					phase_d = '0;
					if (op_q == MOP_RZ2) begin
						state_d = ST_SUM;
					end else begin
						op_d = mul_op_t'(op_q + 4'd1);
					end
				end else begin
					phase_d = phase_q + 3'd1;
				end
			end
			ST_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = ST_ADV;
				adv_d      = ADV_X;
			end
			ST_ADV: begin
				cmd.adv_en = 1'b1;
				if (adv_q == ADV_Z) begin
					state_d = ST_FINISH;
				end else begin
					adv_d = adv_sel_t'(adv_q + 2'd1);
				end
			end
			ST_FINISH: begin
				// output register frees up when empty or when its result transfers now
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after an input transfer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("output register overwritten while stalled");

	a_write_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_wr |-> $past(cmd.mul_acc_en))
		else $error("product written without a final accumulate");

	a_adv_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sum_en |=> cmd.adv_en && cmd.adv_sel == ADV_X)
		else $error("advance did not follow the difference sums");
`endif

endmodule
`default_nettype wire

FILE: hdl/refuge_population_euler_step_unit.sv
// top level of the refuge population euler step unit
`default_nettype none
// Holds warfare, open population and refuge population as unsigned fixed point
// values (STATE_WIDTH bits, half of them fraction) and advances them one time unit
// per step item by the forward difference equations; a load item sets them. Each
// item returns one result with the new state and a flag for top saturation. A load
// item passes from the idle state through the finish state into the output register;
// a step item is paced by the single 32x32 multiplier: 13 products in sequence, each
// as four partial products, last accumulate and write back, then the difference
// sums, the shared advance unit for each state value in turn and the finish state.
// The next item is taken in the cycle after the result enters the output register,
// while that result still waits for transfer out. The user must write coefficients
// through the plain write port only while the block is idle; the block does not enforce this.
module refuge_population_euler_step_unit #(
	parameter int STATE_WIDTH    = rpes_pkg::DEF_STATE_WIDTH,
	parameter int COEF_FRAC_BITS = rpes_pkg::DEF_COEF_FRAC_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire rpes_pkg::in_item_t             in_item,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output rpes_pkg::out_item_t                 out_item,
	input  wire logic                           cfg_we,
	input  wire logic [rpes_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rpes_pkg::COEF_W-1:0]    cfg_data
);
	import rpes_pkg::*;

	cfg_t    cfg;
	dp_cmd_t cmd;

	rpes_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	rpes_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_item.opcode),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	rpes_datapath #(
		.STATE_WIDTH   (STATE_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg),
		.in_item (in_item),
		.out_item(out_item)
	);

endmodule
`default_nettype wire

FILE: tb/tb_refuge_population_euler_step_unit.sv
// self-checking testbench for the refuge population euler step unit
`timescale 1ns / 1ps
module tb_refuge_population_euler_step_unit;
	import rpes_pkg::*;

	localparam int NUM_COEFS       = int'(REG_RETURN_RATE) + 1;
	localparam int CF              = DEF_COEF_FRAC_BITS;
	localparam int SF              = DEF_STATE_WIDTH / 2;
	localparam int RESET_CYCLES    = 11;
	localparam int IDLE_PCT        = 26;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int DRAIN_CYCLES    = 100;
	localparam int MAX_REPORTS     = 10;
	localparam int HOLD_AT         = 60;
	localparam int HOLD_CYCLES     = 600;
	// stretches without any idling on either side
	localparam int SEND_CALM_FROM  = 700;
	localparam int SEND_CALM_TO    = 1000;
	localparam int SINK_CALM_FROM  = 700;
	localparam int SINK_CALM_TO    = 1000;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam logic [COEF_W-1:0]    COEF_MAX       = '1;
	localparam logic [FIELD_W-1:0]   ALL_ONES       = '1;
	localparam logic [FIELD_W-1:0]   PAT_A          = 32'hAAAA_AAAA;
	localparam logic [FIELD_W-1:0]   PAT_5          = 32'h5555_5555;
	localparam logic [FIELD_W-1:0]   ONE_Q16        = 32'h0001_0000;
	localparam logic [63:0]          STATE_MAX      = 64'h0000_0000_FFFF_FFFF;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_COEF_ALL,
		ROW_COEF_ONE
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		in_item_t              item;
		logic [CFG_IDX_W-1:0]  idx;
		logic [COEF_W-1:0]     val;
		bit                    known;
		out_item_t             want;
	} stim_row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	in_item_t             in_item   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_item_t            out_item;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [COEF_W-1:0]    cfg_data  = '0;

	// predictor state and coefficients
	logic [63:0]       pred_war, pred_pop, pred_ref;
	bit                pred_sat;
	logic [COEF_W-1:0] coef [NUM_COEFS];
	logic [COEF_W-1:0] dflt [NUM_COEFS];

	out_item_t  pending_results [$];
	stim_row_t  dir_rows [$];
	int         fail_count   = 0;
	int         sent         = 0;
	int         results_seen = 0;
	int         hold_left    = 0;
	bit         hold_done    = 1'b0;

	always #10 clk = ~clk;

	refuge_population_euler_step_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// exact product shifted right by fb, saturating above 64 bits
	function automatic logic [63:0] mul_fix(input logic [63:0] a, input logic [63:0] b,
			input int fb);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> fb;
		if (prod[127:64] != 64'd0)
			return '1;
		return prod[63:0];
	endfunction

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// old + gain - loss, clamped to zero below and to the state top above
	function automatic logic [63:0] settle(input logic [63:0] old, input logic [63:0] gain,
			input logic [63:0] loss);
		logic [65:0] t;
		t = {2'b00, old} + {2'b00, gain} - {2'b00, loss};
		if (t[65])
			return '0;
		if (t[64:0] > {1'b0, STATE_MAX}) begin
			pred_sat = 1'b1;
			return STATE_MAX;
		end
		return t[63:0];
	endfunction

	function automatic out_item_t next_state(input in_item_t it);
		logic [63:0] x, y, z, cr, cik, cir, ca, cb, cc, cd;
		logic [63:0] ay_k, x_pos, x_neg, ry, ry2, cxy, dzz, rz, rz2;
		out_item_t   res;
		pred_sat = 1'b0;
		if (it.opcode == OP_LOAD) begin
			pred_war = 64'(it.init_warfare) & STATE_MAX;
			pred_pop = 64'(it.init_population) & STATE_MAX;
			pred_ref = 64'(it.init_refuge) & STATE_MAX;
		end else begin
			x   = pred_war;
			y   = pred_pop;
			z   = pred_ref;
			cr  = 64'(coef[REG_GROWTH_RATE]);
			cik = 64'(coef[REG_INV_CAPACITY]);
			cir = 64'(coef[REG_INV_REFUGE_CAPACITY]);
			ca  = 64'(coef[REG_WAR_GROWTH]);
			cb  = 64'(coef[REG_WAR_DECLINE]);
			cc  = 64'(coef[REG_FLEE_RATE]);
			cd  = 64'(coef[REG_RETURN_RATE]);
			ay_k  = mul_fix(mul_fix(ca, y, CF), cik, CF);
			x_pos = mul_fix(x, ay_k, SF);
			x_neg = mul_fix(x, cb, CF);
			ry    = mul_fix(cr, y, CF);
			ry2   = mul_fix(ry, mul_fix(y, cik, CF), SF);
			cxy   = mul_fix(mul_fix(cc, x, CF), y, SF);
			dzz   = mul_fix(cd, z, CF);
			rz    = mul_fix(cr, z, CF);
			rz2   = mul_fix(rz, mul_fix(z, cir, CF), SF);
			pred_war = settle(x, x_pos, x_neg);
			pred_pop = settle(y, add_sat(ry, dzz), add_sat(ry2, cxy));
			pred_ref = settle(z, add_sat(rz, cxy), add_sat(rz2, dzz));
		end
		res.warfare_out    = pred_war[FIELD_W-1:0];
		res.population_out = pred_pop[FIELD_W-1:0];
		res.refuge_out     = pred_ref[FIELD_W-1:0];
		res.saturated      = pred_sat;
		return res;
	endfunction

	function automatic out_item_t echo(input logic [FIELD_W-1:0] w, input logic [FIELD_W-1:0] p,
			input logic [FIELD_W-1:0] r);
		out_item_t res;
		res.warfare_out    = w;
		res.population_out = p;
		res.refuge_out     = r;
		res.saturated      = 1'b0;
		return res;
	endfunction

	function automatic stim_row_t item_row(input logic op, input logic [FIELD_W-1:0] w,
			input logic [FIELD_W-1:0] p, input logic [FIELD_W-1:0] r, input bit known,
			input out_item_t want);
		stim_row_t row;
		row.kind                 = ROW_ITEM;
		row.item.opcode          = op;
		row.item.init_warfare    = w;
		row.item.init_population = p;
		row.item.init_refuge     = r;
		row.idx                  = '0;
		row.val                  = '0;
		row.known                = known;
		row.want                 = want;
		return row;
	endfunction

	function automatic stim_row_t coef_row(input row_kind_t kind,
			input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		stim_row_t row;
		row       = item_row(OP_STEP, '0, '0, '0, 1'b0, '0);
		row.kind  = kind;
		row.idx   = idx;
		row.val   = val;
		return row;
	endfunction

	function automatic logic [COEF_W-1:0] rand_coef();
		case ($urandom_range(9))
			0: return '0;
			1: return COEF_MAX;
			2, 3: return COEF_W'($urandom);
			default: return COEF_W'($urandom_range(0, 1 << CF) >> $urandom_range(0, 12));
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] rand_level();
		case ($urandom_range(9))
			0: return '0;
			1: return ALL_ONES;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h03FF_FFFF);
		endcase
	endfunction

	function automatic void note_fail(input string what, input out_item_t want,
			input out_item_t got);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t %s: expected w=%h p=%h r=%h s=%b, got w=%h p=%h r=%h s=%b",
				$time, what, want.warfare_out, want.population_out, want.refuge_out,
				want.saturated, got.warfare_out, got.population_out, got.refuge_out,
				got.saturated);
	endfunction

	task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
		out_item_t pred;
		int        idle;
		idle = (sent >= SEND_CALM_FROM && sent < SEND_CALM_TO) ? 0 : IDLE_PCT;
		while ($urandom_range(99) < idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do
			@(posedge clk);
		while (in_stall);
		pred = next_state(it);
		pending_results.push_back(known ? want : pred);
		sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (int'(idx) < NUM_COEFS)
			coef[idx] = val;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// result side: checks each transfer and drives random stalls plus one long hold-off
	always @(posedge clk) begin : sink
		out_item_t want;
		int        idle;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_fail("result with nothing pending", '0, out_item);
			end else begin
				want = pending_results.pop_front();
				if (out_item.warfare_out !== want.warfare_out ||
						out_item.population_out !== want.population_out ||
						out_item.refuge_out !== want.refuge_out ||
						out_item.saturated !== want.saturated)
					note_fail("mismatch", want, out_item);
			end
			results_seen++;
		end
		if (hold_left == 0 && !hold_done && results_seen == HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			idle = (results_seen >= SINK_CALM_FROM && results_seen < SINK_CALM_TO) ? 0 : IDLE_PCT;
			out_stall <= ($urandom_range(99) < idle);
		end
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		in_item_t          it;
		logic [COEF_W-1:0] vals [NUM_COEFS];
		int                run_left;
		dflt[REG_GROWTH_RATE]         = RST_GROWTH_RATE;
		dflt[REG_INV_CAPACITY]        = RST_INV_CAPACITY;
		dflt[REG_INV_REFUGE_CAPACITY] = RST_INV_REFUGE_CAPACITY;
		dflt[REG_WAR_GROWTH]          = RST_WAR_GROWTH;
		dflt[REG_WAR_DECLINE]         = RST_WAR_DECLINE;
		dflt[REG_FLEE_RATE]           = RST_FLEE_RATE;
		dflt[REG_RETURN_RATE]         = RST_RETURN_RATE;
		coef     = dflt;
		pred_war = '0;
		pred_pop = '0;
		pred_ref = '0;

		// a step straight out of reset leaves everything at zero
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b1, echo('0, '0, '0)));
		dir_rows.push_back(item_row(OP_LOAD, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
			echo(ALL_ONES, ALL_ONES, ALL_ONES)));
		// full state at default rates: warfare overflows, population collapses
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b0, '0));
		dir_rows.push_back(item_row(OP_STEP, ALL_ONES, ALL_ONES, ALL_ONES, 1'b0, '0));
		dir_rows.push_back(item_row(OP_LOAD, PAT_A, PAT_5, PAT_A, 1'b1, echo(PAT_A, PAT_5, PAT_A)));
		dir_rows.push_back(item_row(OP_LOAD, PAT_5, PAT_A, PAT_5, 1'b1, echo(PAT_5, PAT_A, PAT_5)));
		dir_rows.push_back(item_row(OP_STEP, PAT_A, PAT_5, PAT_A, 1'b0, '0));
		dir_rows.push_back(item_row(OP_LOAD, ONE_Q16, 32'h03E8_0000, 32'h0064_0000, 1'b1,
			echo(ONE_Q16, 32'h03E8_0000, 32'h0064_0000)));
		repeat (3)
			dir_rows.push_back(item_row(OP_STEP, PAT_5, PAT_A, PAT_5, 1'b0, '0));
		dir_rows.push_back(coef_row(ROW_COEF_ALL, '0, COEF_MAX));
		// decline far above the warfare level clamps it to zero
		dir_rows.push_back(item_row(OP_LOAD, ONE_Q16, '0, '0, 1'b1, echo(ONE_Q16, '0, '0)));
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b1, echo('0, '0, '0)));
		dir_rows.push_back(item_row(OP_LOAD, '0, ONE_Q16, '0, 1'b1, echo('0, ONE_Q16, '0)));
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b0, '0));
		dir_rows.push_back(item_row(OP_LOAD, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
			echo(ALL_ONES, ALL_ONES, ALL_ONES)));
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b0, '0));
		// zero coefficients: a step leaves the state untouched
		dir_rows.push_back(coef_row(ROW_COEF_ALL, '0, '0));
		dir_rows.push_back(item_row(OP_LOAD, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 1'b1,
			echo(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9)));
		dir_rows.push_back(item_row(OP_STEP, '0, '0, '0, 1'b1,
			echo(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9)));
		// a write past the last register must not land anywhere
		dir_rows.push_back(coef_row(ROW_COEF_ONE, CFG_IDX_UNUSED, COEF_MAX));
		dir_rows.push_back(item_row(OP_STEP, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1,
			echo(32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9)));

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_ITEM: send_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);
				ROW_COEF_ALL: begin
					wait_idle();
					for (int k = 0; k < NUM_COEFS; k++)
						write_coef(CFG_IDX_W'(k), dir_rows[i].val);
				end
				default: begin
					wait_idle();
					write_coef(dir_rows[i].idx, dir_rows[i].val);
				end
			endcase
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			for (int k = 0; k < NUM_COEFS; k++)
				vals[k] = (ph == 0) ? dflt[k] : (ph == NUM_PHASES - 1) ? COEF_MAX : rand_coef();
			for (int k = 0; k < NUM_COEFS; k++)
				write_coef(CFG_IDX_W'(k), vals[k]);
			run_left = 0;
			repeat (ITEMS_PER_PHASE) begin
				// mostly a load followed by a run of steps, now and then a load cuts in
				if (run_left == 0 || $urandom_range(99) < 4) begin
					it.opcode          = OP_LOAD;
					it.init_warfare    = rand_level();
					it.init_population = rand_level();
					it.init_refuge     = rand_level();
					run_left = $urandom_range(1, 16);
				end else begin
					it.opcode          = OP_STEP;
					it.init_warfare    = $urandom;
					it.init_population = $urandom;
					it.init_refuge     = $urandom;
					run_left--;
				end
				send_item(it, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
